// ===== sv/work_stealing_job_scheduler_core_defines.svh =====
// Assertion macros shared by the work-stealing scheduler RTL.
// Plain text only; included by the files that carry concurrent checks.
`ifndef WORK_STEALING_JOB_SCHEDULER_CORE_DEFINES_SVH
`define WORK_STEALING_JOB_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define WSJS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("work stealing scheduler: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define WSJS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("work stealing scheduler: next-cycle check failed");

`endif

// ===== sv/wsjs_pkg.sv =====
// Shared types, constants and functions for the work-stealing scheduler.
// No dependencies; imported by every module of the block.
package wsjs_pkg;

   // Default sizes.
   localparam int QUEUE_COUNT_DEF = 8;
   localparam int DEQUE_DEPTH_DEF = 256;

   // Width that holds any queue count up to 64, for range checks.
   localparam int CNT_W = 7;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int WORKER_W = 3;
   localparam int HANDLE_W = 16;
   localparam int LEVEL_W  = 9;
   localparam int SEED_W   = 32;
   localparam int WCOUNT_W = 3;

   // Configuration register.
   localparam logic            CSR_WORKER_COUNT   = 1'b0;
   localparam logic [WCOUNT_W-1:0] WORKER_COUNT_RESET = 3'd7;

   // Seed generation.
   localparam logic [SEED_W-1:0] SEED_BASE = 32'hDBAD5EED;
   localparam logic [SEED_W-1:0] SEED_STEP = 32'h9E3779B9;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_FETCH = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // One xorshift32 step with shifts 13, 17 and 5.
   function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] x;
      x = s;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   // Seed that a queue holds after reset; never zero.
   function automatic logic [SEED_W-1:0] seed_init(input logic [CNT_W-1:0] q);
      logic [SEED_W-1:0] s;
      s = SEED_BASE + SEED_W'(q) * SEED_STEP;
      return (s == '0) ? SEED_BASE : s;
   endfunction

endpackage

// ===== sv/wsjs_job_mem.sv =====
// Job handle memory: one write port and one read port, registered read data.
// Depends on wsjs_pkg for the handle width.
module wsjs_job_mem #(
   parameter int DEPTH = wsjs_pkg::QUEUE_COUNT_DEF * wsjs_pkg::DEQUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [wsjs_pkg::HANDLE_W-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [wsjs_pkg::HANDLE_W-1:0] rd_data
);
   import wsjs_pkg::*;

   logic [HANDLE_W-1:0] job_mem [DEPTH];
   logic [HANDLE_W-1:0] rd_data_ff;

   // Write port and read port; the read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         job_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= job_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wsjs_queue_mem.sv =====
// Per-queue state memory: top index, bottom index and random seed per entry.
// Depends on wsjs_pkg; valid bits give reset values without a clearing pass.
module wsjs_queue_mem #(
   parameter int QUEUE_COUNT = wsjs_pkg::QUEUE_COUNT_DEF,
   parameter int DEQUE_DEPTH = wsjs_pkg::DEQUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear_en,
   input  logic                                rd_en,
   input  logic [$clog2(QUEUE_COUNT)-1:0]      rd_addr,
   output logic [$clog2(2*DEQUE_DEPTH)-1:0]    rd_top,
   output logic [$clog2(2*DEQUE_DEPTH)-1:0]    rd_bottom,
   output logic [wsjs_pkg::SEED_W-1:0]         rd_seed,
   input  logic                                wr_en,
   input  logic [$clog2(QUEUE_COUNT)-1:0]      wr_addr,
   input  logic [$clog2(2*DEQUE_DEPTH)-1:0]    wr_top,
   input  logic [$clog2(2*DEQUE_DEPTH)-1:0]    wr_bottom,
   input  logic [wsjs_pkg::SEED_W-1:0]         wr_seed
);
   import wsjs_pkg::*;

   localparam int QW      = $clog2(QUEUE_COUNT);
   localparam int IW      = $clog2(2*DEQUE_DEPTH);
   localparam int ENTRY_W = SEED_W + 2*IW;

   logic [ENTRY_W-1:0]     entry_mem [QUEUE_COUNT];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic [QW-1:0]          rd_addr_ff;
   logic [QUEUE_COUNT-1:0] idx_valid_ff;
   logic [QUEUE_COUNT-1:0] seed_valid_ff;
   logic                   rd_idx_ok_ff;
   logic                   rd_seed_ok_ff;

   // Memory array with read-before-write behaviour.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= {wr_seed, wr_top, wr_bottom};
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Valid bits: indices are cleared by reset and by a clear, seeds by reset only.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_valid_ff  <= '0;
         seed_valid_ff <= '0;
         rd_idx_ok_ff  <= 1'b0;
         rd_seed_ok_ff <= 1'b0;
      end else begin
         if (clear_en) begin
            idx_valid_ff <= '0;
         end else if (wr_en) begin
            idx_valid_ff[wr_addr] <= 1'b1;
         end
         if (wr_en) begin
            seed_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_idx_ok_ff  <= idx_valid_ff[rd_addr];
            rd_seed_ok_ff <= seed_valid_ff[rd_addr];
         end
      end
   end

   // An entry that was never written reads as its reset value.
   assign rd_bottom = rd_idx_ok_ff ? rd_data_ff[IW-1:0] : '0;
   assign rd_top    = rd_idx_ok_ff ? rd_data_ff[2*IW-1:IW] : '0;
   assign rd_seed   = rd_seed_ok_ff ? rd_data_ff[ENTRY_W-1:2*IW]
                                    : seed_init(CNT_W'(rd_addr_ff));

endmodule

// ===== sv/work_stealing_job_scheduler_core.sv =====
// Work-stealing job scheduler: one ring deque of 16-bit job handles per worker
// in a shared job memory, with top, bottom and an xorshift32 seed per worker in
// a small state memory. Both memories have registered read data, and a fetch
// visits them in turn: own state, then victim state if the own deque is empty,
// then the job, which is read only when one is popped or stolen. A push, a clear
// and the unused op code read only the worker's state. Items are handled one at a
// time; a result waiting in the output register does not stop the next word
// being accepted. After reset the block is ready at once: no clearing pass.
// Depends on wsjs_pkg, wsjs_queue_mem and wsjs_job_mem.
`include "work_stealing_job_scheduler_core_defines.svh"

module work_stealing_job_scheduler_core #(
   parameter int QUEUE_COUNT = wsjs_pkg::QUEUE_COUNT_DEF,
   parameter int DEQUE_DEPTH = wsjs_pkg::DEQUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [2:0] worker, [18:3] job_handle, [23:19] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] job_out, [18:16] victim, [27:19] own_level,
                                    // [31:28] zero
   output logic [2:0]  rsp_tuser,   // [0] got_job, [1] was_stolen, [2] push_refused
   // Configuration port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import wsjs_pkg::*;

   localparam int QW   = $clog2(QUEUE_COUNT);
   localparam int IW   = $clog2(2*DEQUE_DEPTH);
   localparam int JOBS = QUEUE_COUNT * DEQUE_DEPTH;
   localparam int AW   = $clog2(JOBS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OWN,
      S_OWN_JOB,
      S_VIC,
      S_VIC_JOB
   } state_type;

   // Index arithmetic modulo twice the deque depth.
   function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
      return (idx == IW'(2*DEQUE_DEPTH - 1)) ? '0 : IW'(idx + 1'b1);
   endfunction

   function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
      return (idx == '0) ? IW'(2*DEQUE_DEPTH - 1) : IW'(idx - 1'b1);
   endfunction

   function automatic logic [IW-1:0] level_of(input logic [IW-1:0] top,
                                              input logic [IW-1:0] bottom);
      logic [IW:0] diff;
      diff = {1'b0, bottom} - {1'b0, top};
      return diff[IW] ? IW'(diff[IW-1:0] + IW'(2*DEQUE_DEPTH)) : diff[IW-1:0];
   endfunction

   // Job memory address of an index in a queue's ring.
   function automatic logic [AW-1:0] job_addr(input logic [QW-1:0] q,
                                              input logic [IW-1:0] idx);
      logic [IW-1:0] slot;
      slot = (idx >= IW'(DEQUE_DEPTH)) ? IW'(idx - IW'(DEQUE_DEPTH)) : idx;
      return AW'(AW'(q) * AW'(DEQUE_DEPTH) + AW'(slot));
   endfunction

   // Control and held request.
   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [WORKER_W-1:0]  worker_ff, worker_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic                 worker_ok_ff, worker_ok_in;
   logic [WORKER_W-1:0]  victim_ff, victim_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [WCOUNT_W-1:0]  worker_count_ff, worker_count_in;

   // Output register.
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [HANDLE_W-1:0]  rsp_job_out_ff, rsp_job_out_in;
   logic                 rsp_got_job_ff, rsp_got_job_in;
   logic                 rsp_was_stolen_ff, rsp_was_stolen_in;
   logic [WORKER_W-1:0]  rsp_victim_ff, rsp_victim_in;
   logic                 rsp_push_refused_ff, rsp_push_refused_in;
   logic [LEVEL_W-1:0]   rsp_own_level_ff, rsp_own_level_in;

   // Memory ports.
   logic                 qm_clear;
   logic                 qm_rd_en;
   logic [QW-1:0]        qm_rd_addr;
   logic [IW-1:0]        q_top;
   logic [IW-1:0]        q_bottom;
   logic [SEED_W-1:0]    q_seed;
   logic                 qm_wr_en;
   logic [QW-1:0]        qm_wr_addr;
   logic [IW-1:0]        qm_wr_top;
   logic [IW-1:0]        qm_wr_bottom;
   logic [SEED_W-1:0]    qm_wr_seed;
   logic                 jm_wr_en;
   logic [AW-1:0]        jm_wr_addr;
   logic                 jm_rd_en;
   logic [AW-1:0]        jm_rd_addr;
   logic [HANDLE_W-1:0]  jm_rd_data;

   // Datapath values.
   logic                 out_free;
   logic                 req_accept;
   logic [IW-1:0]        lvl;
   logic                 lvl_full;
   logic                 lvl_zero;
   logic [SEED_W-1:0]    new_seed;
   logic [WCOUNT_W:0]    worker_span;
   logic [34:0]          pick_prod;
   logic [WORKER_W-1:0]  pick;
   logic                 victim_ok;
   logic                 steal_ok;
   logic                 produce;
   logic                 csr_write;

   wsjs_queue_mem #(
      .QUEUE_COUNT (QUEUE_COUNT),
      .DEQUE_DEPTH (DEQUE_DEPTH)
   ) u_queue_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_en  (qm_clear),
      .rd_en     (qm_rd_en),
      .rd_addr   (qm_rd_addr),
      .rd_top    (q_top),
      .rd_bottom (q_bottom),
      .rd_seed   (q_seed),
      .wr_en     (qm_wr_en),
      .wr_addr   (qm_wr_addr),
      .wr_top    (qm_wr_top),
      .wr_bottom (qm_wr_bottom),
      .wr_seed   (qm_wr_seed)
   );

   wsjs_job_mem #(
      .DEPTH (JOBS)
   ) u_job_mem (
      .clock   (clock),
      .wr_en   (jm_wr_en),
      .wr_addr (jm_wr_addr),
      .wr_data (handle_ff),
      .rd_en   (jm_rd_en),
      .rd_addr (jm_rd_addr),
      .rd_data (jm_rd_data)
   );

   // Configuration register access.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_WORKER_COUNT);
   assign prdata    = (paddr[2] == CSR_WORKER_COUNT) ? {29'd0, worker_count_ff} : 32'd0;
   assign worker_count_in = csr_write ? pwdata[WCOUNT_W-1:0] : worker_count_ff;

   // Level of the queue just read, and the victim pick from the advanced seed.
   assign lvl         = level_of(q_top, q_bottom);
   assign lvl_full    = (lvl >= IW'(DEQUE_DEPTH));
   assign lvl_zero    = (lvl == '0);
   assign new_seed    = xorshift32(q_seed);
   assign worker_span = {1'b0, worker_count_ff} + 1'b1;
   assign pick_prod   = 35'(new_seed) * 35'(worker_span);
   assign pick        = pick_prod[34:32];

   // A steal needs a real queue other than the requester's, and one that is not empty.
   assign victim_ok = ({{(CNT_W-WORKER_W){1'b0}}, victim_ff} < CNT_W'(QUEUE_COUNT));
   assign steal_ok  = victim_ok && (victim_ff != worker_ff) && !lvl_zero;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Sequencer: next state, memory accesses and result fields.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      worker_in    = worker_ff;
      handle_in    = handle_ff;
      worker_ok_in = worker_ok_ff;
      victim_in    = victim_ff;
      level_in     = level_ff;

      qm_clear     = 1'b0;
      qm_rd_en     = 1'b0;
      qm_rd_addr   = QW'(req_tdata[WORKER_W-1:0]);
      qm_wr_en     = 1'b0;
      qm_wr_addr   = QW'(worker_ff);
      qm_wr_top    = q_top;
      qm_wr_bottom = q_bottom;
      qm_wr_seed   = q_seed;
      jm_wr_en     = 1'b0;
      jm_wr_addr   = job_addr(QW'(worker_ff), q_bottom);
      jm_rd_en     = 1'b0;
      jm_rd_addr   = job_addr(QW'(worker_ff), idx_dec(q_bottom));

      produce             = 1'b0;
      rsp_job_out_in      = '0;
      rsp_got_job_in      = 1'b0;
      rsp_was_stolen_in   = 1'b0;
      rsp_victim_in       = '0;
      rsp_push_refused_in = 1'b0;
      rsp_own_level_in    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in        = op_type'(req_tuser);
               worker_in    = req_tdata[WORKER_W-1:0];
               handle_in    = req_tdata[WORKER_W+HANDLE_W-1:WORKER_W];
               worker_ok_in = ({{(CNT_W-WORKER_W){1'b0}}, req_tdata[WORKER_W-1:0]}
                               < CNT_W'(QUEUE_COUNT));
               qm_rd_en     = 1'b1;
               state_in     = S_OWN;
            end
         end
         S_OWN: begin
            if (out_free) begin
               state_in = S_IDLE;
               if (op_ff == OP_CLEAR) begin
                  qm_clear = 1'b1;
                  produce  = 1'b1;
               end else if (!worker_ok_ff) begin
                  produce = 1'b1;
               end else begin
                  case (op_ff)
                     OP_PUSH: begin
                        produce = 1'b1;
                        if (lvl_full) begin
                           rsp_push_refused_in = 1'b1;
                           rsp_own_level_in    = LEVEL_W'(lvl);
                        end else begin
                           jm_wr_en         = 1'b1;
                           qm_wr_en         = 1'b1;
                           qm_wr_bottom     = idx_inc(q_bottom);
                           rsp_own_level_in = LEVEL_W'(IW'(lvl + 1'b1));
                        end
                     end
                     OP_FETCH: begin
                        if (!lvl_zero) begin
                           // Pop the newest job from the own bottom.
                           qm_wr_en     = 1'b1;
                           qm_wr_bottom = idx_dec(q_bottom);
                           jm_rd_en     = 1'b1;
                           level_in     = LEVEL_W'(IW'(lvl - 1'b1));
                           state_in     = S_OWN_JOB;
                        end else begin
                           // Own deque empty: advance the seed and look at a victim.
                           qm_wr_en   = 1'b1;
                           qm_wr_seed = new_seed;
                           qm_rd_en   = 1'b1;
                           qm_rd_addr = QW'(pick);
                           victim_in  = pick;
                           state_in   = S_VIC;
                        end
                     end
                     default: begin
                        produce          = 1'b1;
                        rsp_own_level_in = LEVEL_W'(lvl);
                     end
                  endcase
               end
            end
         end
         S_OWN_JOB: begin
            if (out_free) begin
               produce          = 1'b1;
               rsp_job_out_in   = jm_rd_data;
               rsp_got_job_in   = 1'b1;
               rsp_own_level_in = level_ff;
               state_in         = S_IDLE;
            end
         end
         S_VIC: begin
            if (out_free) begin
               if (steal_ok) begin
                  // Take the oldest job from the victim's top.
                  jm_rd_en   = 1'b1;
                  jm_rd_addr = job_addr(QW'(victim_ff), q_top);
                  qm_wr_en   = 1'b1;
                  qm_wr_addr = QW'(victim_ff);
                  qm_wr_top  = idx_inc(q_top);
                  state_in   = S_VIC_JOB;
               end else begin
                  produce       = 1'b1;
                  rsp_victim_in = victim_ff;
                  state_in      = S_IDLE;
               end
            end
         end
         S_VIC_JOB: begin
            if (out_free) begin
               produce           = 1'b1;
               rsp_job_out_in    = jm_rd_data;
               rsp_got_job_in    = 1'b1;
               rsp_was_stolen_in = 1'b1;
               rsp_victim_in     = victim_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_tvalid_in = produce || (rsp_tvalid_ff && !rsp_tready);
   end

   // State, configuration and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_tvalid_ff   <= 1'b0;
         worker_count_ff <= WORKER_COUNT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
         worker_count_ff <= worker_count_in;
      end
      op_ff        <= op_in;
      worker_ff    <= worker_in;
      handle_ff    <= handle_in;
      worker_ok_ff <= worker_ok_in;
      victim_ff    <= victim_in;
      level_ff     <= level_in;
      if (produce) begin
         rsp_job_out_ff      <= rsp_job_out_in;
         rsp_got_job_ff      <= rsp_got_job_in;
         rsp_was_stolen_ff   <= rsp_was_stolen_in;
         rsp_victim_ff       <= rsp_victim_in;
         rsp_push_refused_ff <= rsp_push_refused_in;
         rsp_own_level_ff    <= rsp_own_level_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_own_level_ff, rsp_victim_ff, rsp_job_out_ff};
   assign rsp_tuser  = {rsp_push_refused_ff, rsp_was_stolen_ff, rsp_got_job_ff};

   // Checks on the sequencer.
   `WSJS_ASSERT_NEXT(a_accept_reads_own, clock, reset, req_accept, state_ff == S_OWN)
   `WSJS_ASSERT_NOW(a_stolen_is_job, clock, reset, rsp_tvalid_ff && rsp_was_stolen_ff, rsp_got_job_ff && !rsp_push_refused_ff)
   `WSJS_ASSERT_NEXT(a_steal_delivers, clock, reset, (state_ff == S_VIC_JOB) && out_free, rsp_tvalid_ff && rsp_got_job_ff && rsp_was_stolen_ff)
   `WSJS_ASSERT_NOW(a_job_port_single, clock, reset, jm_wr_en, !jm_rd_en)

endmodule

// ===== verif/work_stealing_job_scheduler_checker.sv =====
// Checker for the work-stealing scheduler core: watches the request, result and
// register ports, predicts every result word and compares it field by field.
// Depends on wsjs_pkg for field widths, op codes and seed constants.
module work_stealing_job_scheduler_checker #(
   parameter int QUEUE_COUNT = wsjs_pkg::QUEUE_COUNT_DEF,
   parameter int DEQUE_DEPTH = wsjs_pkg::DEQUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [2:0] worker, [18:3] job_handle, [23:19] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [15:0] job_out, [18:16] victim, [27:19] own_level
   input  logic [2:0]  rsp_tuser,   // [0] got_job, [1] was_stolen, [2] push_refused
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count
);
   import wsjs_pkg::*;

   // Top and bottom count modulo twice the depth, so one spare bit tells full from empty.
   localparam int IDX_W = $clog2(2 * DEQUE_DEPTH);
   localparam logic [2:0] WORKER_COUNT_ADDR = {CSR_WORKER_COUNT, 2'b00};

   typedef struct packed {
      logic [HANDLE_W-1:0] job_out;
      logic                got_job;
      logic                was_stolen;
      logic [2:0]          victim;
      logic                push_refused;
      logic [LEVEL_W-1:0]  own_level;
   } sched_result_type;

   // Predicted state of the scheduler.
   logic [HANDLE_W-1:0] job_mem [QUEUE_COUNT][DEQUE_DEPTH];
   logic [IDX_W-1:0]    top_idx [QUEUE_COUNT];
   logic [IDX_W-1:0]    bot_idx [QUEUE_COUNT];
   logic [SEED_W-1:0]   steal_seed [QUEUE_COUNT];
   logic [WCOUNT_W-1:0] worker_count;

   // Results still owed by the block, oldest first.
   sched_result_type expected_results[$];

   function automatic logic [IDX_W-1:0] fill_level(int q);
      return bot_idx[q] - top_idx[q];
   endfunction

   function automatic int slot_of(logic [IDX_W-1:0] idx);
      return int'(idx) % DEQUE_DEPTH;
   endfunction

   // Applies one request word to the predicted state and returns its result.
   function automatic sched_result_type schedule_step(logic [OP_W-1:0] op,
                                                      logic [WORKER_W-1:0] w,
                                                      logic [HANDLE_W-1:0] handle);
      sched_result_type res;
      logic [SEED_W-1:0] x;
      logic [63:0] product;
      logic [31:0] pick;
      res = '0;
      if (op_type'(op) == OP_CLEAR) begin
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            top_idx[q] = '0;
            bot_idx[q] = '0;
         end
      end else if (int'(w) < QUEUE_COUNT) begin
         case (op_type'(op))
            OP_PUSH: begin
               if (fill_level(w) >= DEQUE_DEPTH) begin
                  res.push_refused = 1'b1;
               end else begin
                  job_mem[w][slot_of(bot_idx[w])] = handle;
                  bot_idx[w] = bot_idx[w] + 1'b1;
               end
            end
            OP_FETCH: begin
               if (fill_level(w) > 0) begin
                  // Newest job from the requester's own bottom.
                  bot_idx[w] = bot_idx[w] - 1'b1;
                  res.job_out = job_mem[w][slot_of(bot_idx[w])];
                  res.got_job = 1'b1;
               end else begin
                  // Own deque empty: advance the xorshift seed and pick a victim.
                  x = steal_seed[w];
                  x = x ^ (x << 13);
                  x = x ^ (x >> 17);
                  x = x ^ (x << 5);
                  steal_seed[w] = x;
                  product = 64'(x) * (64'(worker_count) + 64'd1);
                  pick = product[63:32];
                  res.victim = pick[2:0];
                  if (pick < QUEUE_COUNT && pick != 32'(w) && fill_level(pick) > 0) begin
                     res.job_out = job_mem[pick][slot_of(top_idx[pick])];
                     top_idx[pick] = top_idx[pick] + 1'b1;
                     res.got_job = 1'b1;
                     res.was_stolen = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         res.own_level = LEVEL_W'(fill_level(w));
      end
      return res;
   endfunction

   function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      sched_result_type exp_res;
      sched_result_type got_res;
      logic [SEED_W-1:0] s;
      if (reset) begin
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            s = SEED_BASE + SEED_W'(q) * SEED_STEP;
            top_idx[q] = '0;
            bot_idx[q] = '0;
            steal_seed[q] = (s == '0) ? SEED_BASE : s;
         end
         worker_count = WORKER_COUNT_RESET;
         expected_results.delete();
      end else begin
         // Result word: compare against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got_res.job_out = rsp_tdata[15:0];
            got_res.victim = rsp_tdata[18:16];
            got_res.own_level = rsp_tdata[27:19];
            got_res.got_job = rsp_tuser[0];
            got_res.was_stolen = rsp_tuser[1];
            got_res.push_refused = rsp_tuser[2];
            if (expected_results.size() == 0) begin
               $error("result word with none expected: tdata 0x%0h, tuser 0x%0h",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               exp_res = expected_results.pop_front();
               compare_field("job_out", exp_res.job_out, got_res.job_out);
               compare_field("got_job", exp_res.got_job, got_res.got_job);
               compare_field("was_stolen", exp_res.was_stolen, got_res.was_stolen);
               compare_field("victim", exp_res.victim, got_res.victim);
               compare_field("push_refused", exp_res.push_refused, got_res.push_refused);
               compare_field("own_level", exp_res.own_level, got_res.own_level);
            end
         end
         // Request word: predict its result and queue it behind the others.
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    schedule_step(req_tuser, req_tdata[2:0],
                                                  req_tdata[18:3]));
         end
         // Register access phase: track writes, check reads.
         if (psel && penable && pready && paddr == WORKER_COUNT_ADDR) begin
            if (pwrite) begin
               worker_count = pwdata[WCOUNT_W-1:0];
            end else begin
               compare_field("worker_count", 32'(worker_count), prdata);
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== verif/work_stealing_job_scheduler_core_test.sv =====
// Testbench top for the work-stealing scheduler core: drives request words and
// register accesses under several idling patterns and gives the verdict.
// Depends on wsjs_pkg, the core and work_stealing_job_scheduler_checker.
module work_stealing_job_scheduler_core_test;
   import wsjs_pkg::*;

   localparam int DEQUE_DEPTH = DEQUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400_000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] WORKER_COUNT_ADDR = {CSR_WORKER_COUNT, 2'b00};

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [2:0] worker, [18:3] job_handle, [23:19] zero
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] job_out, [18:16] victim, [27:19] own_level
   logic [2:0]  rsp_tuser;        // [0] got_job, [1] was_stolen, [2] push_refused
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int pending_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   work_stealing_job_scheduler_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   work_stealing_job_scheduler_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Result side back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 52; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 52; end
         default:       begin send_idle_pct = 9;  stall_pct = 9;  end
      endcase
   endtask

   // Offers one request word and returns at the falling edge after it is taken.
   // Valid stays high so that a following word can go straight out.
   task automatic send_word(logic [OP_W-1:0] op, logic [WORKER_W-1:0] w,
                            logic [HANDLE_W-1:0] handle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {5'b0, handle, w};
      req_tuser = op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_access(logic write, logic [31:0] value);
      req_tvalid = 1'b0;
      psel = 1'b1;
      pwrite = write;
      paddr = WORKER_COUNT_ADDR;
      pwdata = value;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // Writes the worker count once the block is idle, then reads it back.
   task automatic set_worker_count(logic [WCOUNT_W-1:0] count);
      wait_drained();
      csr_access(1'b1, 32'(count));
      csr_access(1'b0, '0);
   endtask

   // Mixed traffic over all workers; clears are rare so deques build up.
   task automatic random_traffic(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 46) begin
            send_word(OP_PUSH, 3'($urandom_range(7)), 16'($urandom));
         end else if (r < 92) begin
            send_word(OP_FETCH, 3'($urandom_range(7)), 16'($urandom));
         end else if (r < 95) begin
            send_word(OP_CLEAR, 3'($urandom_range(7)), 16'($urandom));
         end else if (r < 98) begin
            send_word(OP_UNUSED, 3'($urandom_range(7)), 16'($urandom));
         end else begin
            wait_drained();
         end
      end
   endtask

   // With one queue in use every idle worker steals from queue 0. Fill it, then
   // alternate steals and pushes so that both indices run past the wrap point.
   task automatic steal_stream();
      send_word(OP_CLEAR, 3'd0, 16'd0);
      repeat (DEQUE_DEPTH + 2) send_word(OP_PUSH, 3'd0, 16'($urandom));
      repeat (DEQUE_DEPTH + 12) begin
         send_word(OP_FETCH, 3'($urandom_range(7, 1)), 16'($urandom));
         send_word(OP_PUSH, 3'd0, 16'($urandom));
         if ($urandom_range(9) == 0) send_word(OP_PUSH, 3'd0, 16'($urandom));
      end
      repeat (4) send_word(OP_FETCH, 3'd0, 16'd0);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed words with all eight queues in use: own pops, steal attempts
      // on empty deques, handle extremes, the unused op code and a clear.
      set_idling(IDLE_NONE);
      csr_access(1'b0, '0);
      send_word(OP_FETCH, 3'd0, 16'd0);
      send_word(OP_PUSH, 3'd0, 16'hFFFF);
      send_word(OP_PUSH, 3'd0, 16'h0000);
      send_word(OP_PUSH, 3'd7, 16'hA5A5);
      send_word(OP_PUSH, 3'd7, 16'h5A5A);
      send_word(OP_PUSH, 3'd3, 16'h8001);
      send_word(OP_FETCH, 3'd0, 16'd0);
      send_word(OP_FETCH, 3'd0, 16'd0);
      send_word(OP_FETCH, 3'd0, 16'd0);
      send_word(OP_FETCH, 3'd5, 16'd0);
      send_word(OP_FETCH, 3'd6, 16'd0);
      send_word(OP_FETCH, 3'd1, 16'd0);
      send_word(OP_UNUSED, 3'd7, 16'h1234);
      send_word(OP_UNUSED, 3'd2, 16'd0);
      send_word(OP_CLEAR, 3'd0, 16'd0);
      send_word(OP_FETCH, 3'd7, 16'd0);
      send_word(OP_PUSH, 3'd4, 16'h7FFF);

      // A single queue in use: a worker stealing from queue 0, and worker 0
      // choosing itself as victim.
      set_worker_count(3'd0);
      send_word(OP_PUSH, 3'd0, 16'hBEEF);
      send_word(OP_PUSH, 3'd0, 16'h0F0F);
      send_word(OP_FETCH, 3'd3, 16'd0);
      send_word(OP_FETCH, 3'd0, 16'd0);
      send_word(OP_FETCH, 3'd0, 16'd0);
      send_word(OP_FETCH, 3'd6, 16'd0);
      send_word(OP_CLEAR, 3'd0, 16'd0);

      set_worker_count(3'd3);
      set_idling(IDLE_SENDER);
      random_traffic(150);

      set_worker_count(3'd7);
      set_idling(IDLE_RECEIVER);
      random_traffic(150);

      set_worker_count(3'd0);
      set_idling(IDLE_BOTH);
      steal_stream();

      set_worker_count(3'd1);
      set_idling(IDLE_NONE);
      random_traffic(100);

      wait_drained();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/wsjs_pkg.sv
sv/wsjs_job_mem.sv
sv/wsjs_queue_mem.sv
sv/work_stealing_job_scheduler_core.sv
verif/work_stealing_job_scheduler_checker.sv
verif/work_stealing_job_scheduler_core_test.sv
